[rtl/core/backward_gradient_adjoint_3d_assert.svh]
// Assertion macros shared by the divergence core modules.
`ifndef BACKWARD_GRADIENT_ADJOINT_3D_ASSERT_SVH
`define BACKWARD_GRADIENT_ADJOINT_3D_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BGA3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BGA3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bga3_pkg.sv]
// Shared types and constants for the 3-D divergence core.
`timescale 1ns / 1ps
package bga3_pkg;
  localparam int MAX_NX  = 128;
  localparam int MAX_NY  = 128;
  localparam int MAX_NZ  = 1024;
  localparam int AW      = 15;
  localparam int DEPTH   = 1 << AW;
  localparam int CW      = 25;
  localparam int FIFO_AW = 2;
  localparam int FIFO_D  = 1 << FIFO_AW;

  typedef logic [AW-1:0] addr_t;

  typedef enum logic [2:0] {
    REG_SIZE_X   = 3'd0,
    REG_SIZE_Y   = 3'd1,
    REG_SIZE_Z   = 3'd2,
    REG_WEIGHT_X = 3'd3,
    REG_WEIGHT_Y = 3'd4,
    REG_WEIGHT_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    addr_t ac;
    addr_t ax;
    addr_t ay;
    addr_t az;
    logic  bx;
    logic  by;
    logic  bz;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic               en;
    addr_t              addr;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } wr_t;
endpackage

[rtl/core/bga3_fifo.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module bga3_fifo import bga3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);
  cmd_t               mem [FIFO_D];
  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_cmd;
    end
  end

  assign pop_cmd = mem[rp_r];
  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_D));
  assign empty   = (cnt_r == '0);
endmodule

[rtl/core/bga3_front.sv]
// Front end: configuration, request classification, history writes, command issue.
`timescale 1ns / 1ps
module bga3_front import bga3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic signed [31:0] in_x_val,
  input  logic signed [31:0] in_y_val,
  input  logic signed [31:0] in_z_val,
  input  logic               fifo_full,
  input  logic               fifo_empty,
  output logic               push,
  output cmd_t               push_cmd,
  output wr_t                wr,
  output logic signed [31:0] weight_x,
  output logic signed [31:0] weight_y,
  output logic signed [31:0] weight_z
);
  logic [7:0]         nx_r, nx_nxt, ny_r, ny_nxt;
  logic [10:0]        nz_r, nz_nxt;
  logic signed [31:0] wx_r, wx_nxt, wy_r, wy_nxt, wz_r, wz_nxt;
  logic [AW-1:0]      plane_r, plane_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  logic [1:0]         settle_r, settle_nxt;
  logic [CW-1:0]      in_cnt_r, in_cnt_nxt, out_cnt_r, out_cnt_nxt;
  logic [6:0]         oi_r, oi_nxt, oj_r, oj_nxt;
  logic [9:0]         ok_r, ok_nxt;
  logic               acc, room, push_data, push_drain, is_last;
  logic               bx, by, bz;
  logic [7:0]         c8;
  logic [10:0]        c11;
  logic [15:0]        plane_prod;
  logic [25:0]        total_prod;
  addr_t              l;

  assign c8  = cfg_data[7:0];
  assign c11 = cfg_data[10:0];
  assign plane_prod = nx_r * ny_r;
  assign total_prod = plane_r * nz_r;

  assign in_ready   = (settle_r == 2'd0) && !fifo_full && !((in_cnt_r == '0) && !fifo_empty);
  assign acc        = in_valid && in_ready;
  assign room       = in_cnt_r < total_r;
  assign push_data  = acc && !in_func && room && (in_cnt_r >= CW'(plane_r));
  assign push_drain = acc && in_func && !room && (out_cnt_r < total_r);
  assign push       = push_data || push_drain;
  assign is_last    = push_drain && ((out_cnt_r + 1'b1) == total_r);

  assign bx = ({1'b0, oi_r} == nx_r - 8'd1);
  assign by = ({1'b0, oj_r} == ny_r - 8'd1);
  assign bz = ({1'b0, ok_r} == nz_r - 11'd1);
  assign l  = out_cnt_r[AW-1:0];

  always_comb begin
    push_cmd.ac   = l;
    push_cmd.ax   = bx ? l - addr_t'(1) : l + addr_t'(1);
    push_cmd.ay   = by ? l - addr_t'(ny_r == 8'd0 ? 8'd0 : nx_r) : l + addr_t'(nx_r);
    push_cmd.az   = bz ? l - plane_r : l + plane_r;
    push_cmd.bx   = bx;
    push_cmd.by   = by;
    push_cmd.bz   = bz;
    push_cmd.last = is_last;
    wr.en   = acc && !in_func && room;
    wr.addr = in_cnt_r[AW-1:0];
    wr.x    = in_x_val;
    wr.y    = in_y_val;
    wr.z    = in_z_val;
  end

  always_comb begin
    nx_nxt      = nx_r;
    ny_nxt      = ny_r;
    nz_nxt      = nz_r;
    wx_nxt      = wx_r;
    wy_nxt      = wy_r;
    wz_nxt      = wz_r;
    plane_nxt   = plane_r;
    total_nxt   = total_r;
    settle_nxt  = settle_r;
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    oi_nxt      = oi_r;
    oj_nxt      = oj_r;
    ok_nxt      = ok_r;

    case (settle_r)
      2'd2: begin
        plane_nxt  = plane_prod[AW-1:0];
        settle_nxt = 2'd1;
      end
      2'd1: begin
        total_nxt  = total_prod[CW-1:0];
        settle_nxt = 2'd0;
      end
      default: ;
    endcase

    if (wr.en) begin
      in_cnt_nxt = in_cnt_r + 1'b1;
    end
    if (push) begin
      out_cnt_nxt = out_cnt_r + 1'b1;
      if (bx) begin
        oi_nxt = '0;
        if (by) begin
          oj_nxt = '0;
          ok_nxt = ok_r + 1'b1;
        end else begin
          oj_nxt = oj_r + 1'b1;
        end
      end else begin
        oi_nxt = oi_r + 1'b1;
      end
    end
    if (is_last) begin
      in_cnt_nxt  = '0;
      out_cnt_nxt = '0;
      oi_nxt      = '0;
      oj_nxt      = '0;
      ok_nxt      = '0;
    end

    if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_SIZE_X:   nx_nxt = (c8 < 8'd2) ? 8'd2 : ((c8 > 8'(MAX_NX)) ? 8'(MAX_NX) : c8);
        REG_SIZE_Y:   ny_nxt = (c8 < 8'd2) ? 8'd2 : ((c8 > 8'(MAX_NY)) ? 8'(MAX_NY) : c8);
        REG_SIZE_Z:   nz_nxt = (c11 < 11'd2) ? 11'd2 :
                               ((c11 > 11'(MAX_NZ)) ? 11'(MAX_NZ) : c11);
        REG_WEIGHT_X: wx_nxt = cfg_data;
        REG_WEIGHT_Y: wy_nxt = cfg_data;
        REG_WEIGHT_Z: wz_nxt = cfg_data;
        default: ;
      endcase
      if ((cfg_idx == REG_SIZE_X) || (cfg_idx == REG_SIZE_Y) || (cfg_idx == REG_SIZE_Z)) begin
        settle_nxt  = 2'd2;
        in_cnt_nxt  = '0;
        out_cnt_nxt = '0;
        oi_nxt      = '0;
        oj_nxt      = '0;
        ok_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r      <= 8'd2;
      ny_r      <= 8'd2;
      nz_r      <= 11'd2;
      wx_r      <= -32'sd65536;
      wy_r      <= -32'sd65536;
      wz_r      <= -32'sd65536;
      plane_r   <= AW'(4);
      total_r   <= CW'(8);
      settle_r  <= 2'd0;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      oi_r      <= '0;
      oj_r      <= '0;
      ok_r      <= '0;
    end else begin
      nx_r      <= nx_nxt;
      ny_r      <= ny_nxt;
      nz_r      <= nz_nxt;
      wx_r      <= wx_nxt;
      wy_r      <= wy_nxt;
      wz_r      <= wz_nxt;
      plane_r   <= plane_nxt;
      total_r   <= total_nxt;
      settle_r  <= settle_nxt;
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      oi_r      <= oi_nxt;
      oj_r      <= oj_nxt;
      ok_r      <= ok_nxt;
    end
  end

  assign weight_x = wx_r;
  assign weight_y = wy_r;
  assign weight_z = wz_r;

`include "backward_gradient_adjoint_3d_assert.svh"
  `BGA3_ASSERT_NOW(a_out_behind_in, 1'b1, out_cnt_r <= in_cnt_r, "output count ahead of input")
  `BGA3_ASSERT_NOW(a_push_room, push, !fifo_full, "command pushed into full queue")
  `BGA3_ASSERT_NOW(a_write_bound, wr.en, in_cnt_r < total_r, "history write past volume")
  `BGA3_ASSERT_NEXT(a_last_clears, push && is_last && !cfg_we, (in_cnt_r == '0) && (out_cnt_r == '0), "counters not cleared after last")
endmodule

[rtl/core/bga3_back.sv]
// Back end: plane history memories, difference, weighting, rounding and output register.
`timescale 1ns / 1ps
module bga3_back import bga3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  wr_t                wr,
  input  cmd_t               cmd,
  input  logic               fifo_empty,
  output logic               pop,
  input  logic signed [31:0] weight_x,
  input  logic signed [31:0] weight_y,
  input  logic signed [31:0] weight_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_du_val,
  output logic               out_last
);
  logic signed [31:0] mem_x [DEPTH];
  logic signed [31:0] mem_y [DEPTH];
  logic signed [31:0] mem_z [DEPTH];

  logic               en;
  logic               s1_v_r, s2_v_r, out_v_r;
  logic signed [31:0] cx_r, nbx_r, cy_r, nby_r, cz_r, nbz_r;
  logic               bx_r, by_r, bz_r, l1_r, l2_r, out_last_r;
  logic signed [32:0] dx, dy, dz;
  logic signed [64:0] px_r, py_r, pz_r;
  logic signed [66:0] rnd;
  logic signed [31:0] du, du_r;

  assign en  = !out_v_r || out_ready;
  assign pop = en && !fifo_empty;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_x[wr.addr] <= wr.x;
      mem_y[wr.addr] <= wr.y;
      mem_z[wr.addr] <= wr.z;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx_r  <= mem_x[cmd.ac];
      nbx_r <= mem_x[cmd.ax];
      cy_r  <= mem_y[cmd.ac];
      nby_r <= mem_y[cmd.ay];
      cz_r  <= mem_z[cmd.ac];
      nbz_r <= mem_z[cmd.az];
      bx_r  <= cmd.bx;
      by_r  <= cmd.by;
      bz_r  <= cmd.bz;
      l1_r  <= cmd.last;
    end
  end

  always_comb begin
    dx = bx_r ? {cx_r[31], cx_r} - {nbx_r[31], nbx_r} : {nbx_r[31], nbx_r} - {cx_r[31], cx_r};
    dy = by_r ? {cy_r[31], cy_r} - {nby_r[31], nby_r} : {nby_r[31], nby_r} - {cy_r[31], cy_r};
    dz = bz_r ? {cz_r[31], cz_r} - {nbz_r[31], nbz_r} : {nbz_r[31], nbz_r} - {cz_r[31], cz_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= weight_x * dx;
      py_r <= weight_y * dy;
      pz_r <= weight_z * dz;
      l2_r <= l1_r;
    end
  end

  // round half up to Q16.16, then saturate
  always_comb begin
    rnd = {{2{px_r[64]}}, px_r} + {{2{py_r[64]}}, py_r} + {{2{pz_r[64]}}, pz_r}
          + 67'sd32768;
    if ((&rnd[66:47]) || !(|rnd[66:47])) begin
      du = rnd[47:16];
    end else begin
      du = rnd[66] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      du_r       <= du;
      out_last_r <= l2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= !fifo_empty;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  assign out_valid  = out_v_r;
  assign out_du_val = du_r;
  assign out_last   = out_last_r;

`include "backward_gradient_adjoint_3d_assert.svh"
  `BGA3_ASSERT_NEXT(a_stall_holds_s2, s2_v_r && !en, s2_v_r, "stage two lost during stall")
  `BGA3_ASSERT_NOW(a_pop_only_adv, pop, en, "pop while pipeline stalled")
  `BGA3_ASSERT_NEXT(a_s1_feeds_s2, s1_v_r && en, s2_v_r, "stage one result dropped")
endmodule

[rtl/core/backward_gradient_adjoint_3d.sv]
// Top level of the streaming 3-D finite-difference divergence core.
// Throughput: one request per cycle while in_ready is high; result for voxel l issues
// when voxel l+plane arrives, then passes the queue, read, multiply and output registers.
// Input stalls while a size write settles, and at a new volume until the queue drains.
// Reset (synchronous, rst_n low): counters cleared, sizes 2, weights -1.0, queue empty.
// The plane history memories are not cleared; only data written this volume is read.
`timescale 1ns / 1ps
module backward_gradient_adjoint_3d import bga3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic signed [31:0] in_x_val,
  input  logic signed [31:0] in_y_val,
  input  logic signed [31:0] in_z_val,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_du_val,
  output logic               out_last
);
  logic               fifo_full, fifo_empty, push, pop;
  cmd_t               push_cmd, pop_cmd;
  wr_t                wr;
  logic signed [31:0] wx, wy, wz;

  bga3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_x_val   (in_x_val),
    .in_y_val   (in_y_val),
    .in_z_val   (in_z_val),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty),
    .push       (push),
    .push_cmd   (push_cmd),
    .wr         (wr),
    .weight_x   (wx),
    .weight_y   (wy),
    .weight_z   (wz)
  );

  bga3_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  bga3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .cmd        (pop_cmd),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .weight_x   (wx),
    .weight_y   (wy),
    .weight_z   (wz),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_du_val (out_du_val),
    .out_last   (out_last)
  );
endmodule

[tb/backward_gradient_adjoint_3d_checker.sv]
// Checker for the 3-D divergence core: predicts each result and compares it.
`timescale 1ns / 1ps
module backward_gradient_adjoint_3d_checker import bga3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  logic signed [31:0] in_x_val,
  input  logic signed [31:0] in_y_val,
  input  logic signed [31:0] in_z_val,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_du_val,
  input  logic               out_last,
  output int                 failures,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } voxel_t;

  typedef struct packed {
    logic signed [31:0] du;
    logic               last;
  } div_t;

  voxel_t             plane_store [DEPTH];
  int unsigned        voxels_in, sums_out;
  logic [7:0]         nx_reg, ny_reg;
  logic [10:0]        nz_reg;
  logic signed [31:0] wx, wy, wz;
  div_t               expected_divs[$];

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    return (v < 2) ? 2 : ((v > hi) ? hi : v);
  endfunction

  function automatic voxel_t voxel_at(int unsigned l);
    return plane_store[l % DEPTH];
  endfunction

  function automatic logic signed [31:0] divergence(int unsigned l, int unsigned nx,
                                                    int unsigned ny, int unsigned nz);
    int unsigned        plane;
    voxel_t             c;
    logic signed [32:0] dx, dy, dz;
    logic signed [69:0] acc;
    plane = nx * ny;
    c = voxel_at(l);
    if ((l % nx) + 1 < nx) dx = voxel_at(l + 1).cx - c.cx;
    else dx = c.cx - voxel_at(l - 1).cx;
    if (((l / nx) % ny) + 1 < ny) dy = voxel_at(l + nx).cy - c.cy;
    else dy = c.cy - voxel_at(l - nx).cy;
    if ((l / plane) + 1 < nz) dz = voxel_at(l + plane).cz - c.cz;
    else dz = c.cz - voxel_at(l - plane).cz;
    acc = wx * dx + wy * dy + wz * dz;
    acc = (acc + 70'sd32768) >>> 16;
    if (acc > 70'sd2147483647) return 32'sh7fffffff;
    if (acc < -70'sd2147483648) return 32'sh80000000;
    return acc[31:0];
  endfunction

  task automatic take_request();
    int unsigned nx, ny, nz, plane, total;
    voxel_t      v;
    div_t        d;
    nx = clamp_size(nx_reg, MAX_NX);
    ny = clamp_size(ny_reg, MAX_NY);
    nz = clamp_size(nz_reg, MAX_NZ);
    plane = nx * ny;
    total = plane * nz;
    if (!in_func) begin
      if (voxels_in >= total) return;
      v.cx = in_x_val;
      v.cy = in_y_val;
      v.cz = in_z_val;
      plane_store[voxels_in % DEPTH] = v;
      voxels_in++;
      if (voxels_in <= plane) return;
      d.du = divergence(sums_out, nx, ny, nz);
      d.last = 1'b0;
      sums_out++;
      expected_divs.push_back(d);
    end else begin
      if (voxels_in < total || sums_out >= total) return;
      d.du = divergence(sums_out, nx, ny, nz);
      sums_out++;
      d.last = (sums_out == total);
      if (d.last) begin
        voxels_in = 0;
        sums_out = 0;
      end
      expected_divs.push_back(d);
    end
  endtask

  always @(posedge clk) begin
    div_t e;
    if (!rst_n) begin
      voxels_in = 0;
      sums_out = 0;
      nx_reg = 8'd2;
      ny_reg = 8'd2;
      nz_reg = 11'd2;
      wx = -32'sd65536;
      wy = -32'sd65536;
      wz = -32'sd65536;
      failures = 0;
      expected_divs.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_SIZE_X:   begin nx_reg = cfg_data[7:0];  voxels_in = 0; sums_out = 0; end
          REG_SIZE_Y:   begin ny_reg = cfg_data[7:0];  voxels_in = 0; sums_out = 0; end
          REG_SIZE_Z:   begin nz_reg = cfg_data[10:0]; voxels_in = 0; sums_out = 0; end
          REG_WEIGHT_X: wx = cfg_data;
          REG_WEIGHT_Y: wy = cfg_data;
          REG_WEIGHT_Z: wz = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_divs.size() == 0) begin
          $error("unexpected result du_val=%0d last=%0b", out_du_val, out_last);
          failures++;
        end else begin
          e = expected_divs.pop_front();
          if (out_du_val !== e.du) begin
            $error("du_val: expected %0d, got %0d", e.du, out_du_val);
            failures++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_last);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) take_request();
    end
    pending = expected_divs.size();
  end

endmodule

[tb/backward_gradient_adjoint_3d_test.sv]
// Stimulus and verdict for the 3-D divergence core testbench.
`timescale 1ns / 1ps
module backward_gradient_adjoint_3d_test;
  import bga3_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_idx = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_func = 1'b0;
  logic signed [31:0] in_x_val = '0;
  logic signed [31:0] in_y_val = '0;
  logic signed [31:0] in_z_val = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_du_val;
  logic               out_last;
  int                 failures, pending;

  bit no_gaps;
  int hold_asked, hold_done;
  int data_sent;

  always #5 clk = ~clk;

  backward_gradient_adjoint_3d DUT (.*);
  backward_gradient_adjoint_3d_checker chk (.*);

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [31:0] sample32();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] weight32();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return -($urandom_range(1, 8) << 16);
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random back-pressure, plus a long hold-off when asked
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done++;
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic push(input logic f, input logic [31:0] x, y, z);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_x_val <= x;
    in_y_val <= y;
    in_z_val <= z;
    do @(posedge clk); while (!in_ready);
    if (!f) data_sent++;
  endtask

  task automatic push_voxel();
    push(1'b0, sample32(), sample32(), sample32());
  endtask

  task automatic push_drain();
    push(1'b1, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
  endtask

  task automatic configure(input logic [31:0] sx, sy, sz, wxv, wyv, wzv);
    wait_idle();
    cfg_write(REG_SIZE_X, sx);
    cfg_write(REG_SIZE_Y, sy);
    cfg_write(REG_SIZE_Z, sz);
    cfg_write(REG_WEIGHT_X, wxv);
    cfg_write(REG_WEIGHT_Y, wyv);
    cfg_write(REG_WEIGHT_Z, wzv);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int used(input int v, input int hi);
    return (v < 2) ? 2 : ((v > hi) ? hi : v);
  endfunction

  // one volume; style: 0 clean, 1 early drains, 2 surplus data, 3 abandoned,
  // 4 long output hold-off from the first result, 5 sender pause with
  // mid-volume weight change
  task automatic volume(input int sx, sy, sz, input int style);
    int total, plane, cut;
    plane = used(sx, MAX_NX) * used(sy, MAX_NY);
    total = plane * used(sz, MAX_NZ);
    cut = $urandom_range(1, total - 1);
    if (style == 4) cut = plane;
    if (style == 3) begin
      repeat (cut) push_voxel();
      return;
    end
    for (int n = 0; n < total; n++) begin
      if (style == 1 && $urandom_range(0, 7) == 0) push_drain();
      if (n == cut && style == 4) hold_asked++;
      if (n == cut && style == 5) begin
        wait_idle();
        cfg_write(REG_WEIGHT_X, weight32());
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      push_voxel();
    end
    if (style == 2) repeat ($urandom_range(1, 4)) push_voxel();
    repeat (plane) push_drain();
  endtask

  initial begin
    int sx, sy, sz;
    no_gaps = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes and weights: early drains, then an extreme-valued volume
    push_drain();
    push(1'b0, 32'h80000000, 32'h7fffffff, 32'h80000000);
    push_drain();
    push(1'b0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push(1'b0, 32'h0, 32'hffffffff, 32'h0);
    push(1'b0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    repeat (4) push_voxel();
    push(1'b0, 32'h1, 32'h1, 32'h1);
    repeat (4) push_drain();
    push_drain();

    configure(2, 2, 2, 32'h80000000, 32'h80000000, 32'h80000000);
    volume(2, 2, 2, 2);
    configure(0, 1, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    volume(0, 1, 0, 1);

    while (data_sent < 350) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        sx = $urandom_range(0, 255);
        sy = $urandom_range(0, 2);
        sz = $urandom_range(0, 2);
      end else begin
        sx = $urandom_range(2, 6);
        sy = $urandom_range(2, 4);
        sz = $urandom_range(2, 4);
      end
      configure(sx, sy, sz, weight32(), weight32(), weight32());
      volume(sx, sy, sz, $urandom_range(0, 5));
    end

    no_gaps = 1'b0;
    configure(255, 2, 2, weight32(), weight32(), weight32());
    volume(255, 2, 2, 4);
    configure(2, 200, 2, weight32(), weight32(), weight32());
    volume(2, 200, 2, 3);

    wait_idle();
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
